// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

   localparam int MaxHeight  = 512;
   localparam int MaxWidth   = 512;
   localparam int HalfWindow = 3;
   localparam int MaxSearch  = 63;

   localparam int CfgIdxWidth = 2;
   localparam logic [CfgIdxWidth-1:0] CfgHeight = 2'd0;
   localparam logic [CfgIdxWidth-1:0] CfgWidth  = 2'd1;
   localparam logic [CfgIdxWidth-1:0] CfgRange  = 2'd2;

   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

endpackage

// ===== hdl/ssd_cell.sv =====
// one candidate accumulator: adds per-pixel absolute differences into the window cost
module ssd_cell #(
   parameter int CostWidth = 14
) (
   input  logic                 clock,
   input  logic                 clear,
   input  logic                 add_en,
   input  logic [CostWidth-1:0] add_value,
   input  logic [CostWidth-1:0] shift_value,
   input  logic                 shift_en,
   output logic [CostWidth-1:0] cost
);
   logic [CostWidth-1:0] cost_ff, cost_in;

   // clear, accumulate, or pass the neighbour's cost along the chain
   always_comb begin
      cost_in = cost_ff;
      if (clear) cost_in = '0;
      else if (shift_en) cost_in = shift_value;
      else if (add_en) cost_in = cost_ff + add_value;
   end

   always_ff @(posedge clock) begin
      cost_ff <= cost_in;
   end

   assign cost = cost_ff;
endmodule

// ===== hdl/stereo_sad_disparity.sv =====
// Stereo block matching by sum of absolute differences over a (2*HALF_WINDOW+1)
// square window clamped at the image borders, with parabolic subpixel refinement
// in Q.4. A write transaction (command 0) stores a left/right pixel pair and is
// taken without leaving idle, as is a query outside the image, with no result.
// A query reads the window pixel by pixel from the image memories, an address
// state and then a read state of registered data per pixel, for every candidate
// d = 0..maxd; each memory has a single read port. Input is held off while a
// query runs. A chain of cells, one per candidate, keeps the costs and shifts
// them towards the comparator one candidate per cycle, then a four-step divider
// forms the parabola offset. A result that is not taken stalls the block only
// once the next query is done.
module stereo_sad_disparity #(
   parameter int MAX_HEIGHT  = ssd_pkg::MaxHeight,
   parameter int MAX_WIDTH   = ssd_pkg::MaxWidth,
   parameter int HALF_WINDOW = ssd_pkg::HalfWindow,
   parameter int MAX_SEARCH  = ssd_pkg::MaxSearch
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // row[8:0], col[17:9], left_pixel[25:18], right_pixel[33:26]
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // disparity_q4[9:0], best_cost[23:10]
   output logic        rsp_tuser,  // interpolated
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ssd_pkg::CfgIdxWidth-1:0] csr_index,
   input  logic [9:0]  csr_data
);
   localparam int RowW  = $clog2(MAX_HEIGHT);
   localparam int ColW  = $clog2(MAX_WIDTH);
   localparam int DW    = $clog2(MAX_SEARCH + 1);
   localparam int NCand = MAX_SEARCH + 1;
   localparam int CW    = 24;
   localparam int NW    = CW + 4;
   localparam int Depth = MAX_HEIGHT * MAX_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_ADDR, S_READ, S_ACC, S_SEARCH, S_PREP, S_DIV, S_DONE
   } state_type;

   state_type state_ff;

   // image memories
   logic [7:0] left_mem  [Depth];
   logic [7:0] right_mem [Depth];
   logic [RowW+ColW-1:0] raddr_l, raddr_r;
   logic [7:0] lpix_ff, rpix_ff;

   // configuration
   logic [9:0] height_ff, width_ff;
   logic [5:0] range_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 10'd375;
         width_ff  <= 10'd450;
         range_ff  <= 6'd50;
      end else if (csr_valid) begin
         unique case (csr_index)
            ssd_pkg::CfgHeight: height_ff <= csr_data;
            ssd_pkg::CfgWidth:  width_ff  <= csr_data;
            ssd_pkg::CfgRange:  range_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // saturated dimensions
   logic [12:0] h_sat, w_sat, rng_sat;
   always_comb begin
      h_sat = (height_ff == 0) ? 13'd1 :
              ({3'd0, height_ff} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {3'd0, height_ff};
      w_sat = (width_ff == 0) ? 13'd1 :
              ({3'd0, width_ff} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {3'd0, width_ff};
      rng_sat = ({7'd0, range_ff} > 13'(MAX_SEARCH)) ? 13'(MAX_SEARCH) : {7'd0, range_ff};
   end

   wire        cmd   = req_tuser;
   wire [8:0]  q_row = req_tdata[8:0];
   wire [8:0]  q_col = req_tdata[17:9];

   // query geometry
   logic [12:0] r0_ff, r1_ff, c0_ff, c1_ff, maxd_ff, r_ff, c_ff, d_ff;
   logic [12:0] r0_in, r1_in, c0_in, c1_in, maxd_in, wlim;
   always_comb begin
      r0_in = ({4'd0, q_row} < 13'(HALF_WINDOW)) ? 13'd0 : {4'd0, q_row} - 13'(HALF_WINDOW);
      r1_in = ({4'd0, q_row} + 13'(HALF_WINDOW) > h_sat - 13'd1) ? h_sat - 13'd1
              : {4'd0, q_row} + 13'(HALF_WINDOW);
      c0_in = ({4'd0, q_col} < 13'(HALF_WINDOW)) ? 13'd0 : {4'd0, q_col} - 13'(HALF_WINDOW);
      c1_in = ({4'd0, q_col} + 13'(HALF_WINDOW) > w_sat - 13'd1) ? w_sat - 13'd1
              : {4'd0, q_col} + 13'(HALF_WINDOW);
      wlim  = w_sat - 13'd1 - c1_in;
      maxd_in = (wlim < rng_sat) ? wlim : rng_sat;
   end

   assign raddr_r = {r_ff[RowW-1:0], c_ff[ColW-1:0]};
   wire [12:0] cl = c_ff + d_ff;
   assign raddr_l = {r_ff[RowW-1:0], cl[ColW-1:0]};

   // memory ports
   wire wr_go = req_tvalid && req_tready && cmd == ssd_pkg::CmdWrite
                && ({4'd0, q_row} < 13'(MAX_HEIGHT)) && ({4'd0, q_col} < 13'(MAX_WIDTH));
   always_ff @(posedge clock) begin
      if (wr_go) begin
         left_mem [{q_row[RowW-1:0], q_col[ColW-1:0]}] <= req_tdata[25:18];
         right_mem[{q_row[RowW-1:0], q_col[ColW-1:0]}] <= req_tdata[33:26];
      end
      lpix_ff <= left_mem[raddr_l];
      rpix_ff <= right_mem[raddr_r];
   end

   // cell chain: cell i accumulates candidate i; shift moves costs towards cell 0
   logic [CW-1:0] cost [NCand];
   logic clear_ff, add_ff, shift_ff;
   logic [CW-1:0] absd;
   assign absd = CW'((lpix_ff > rpix_ff) ? lpix_ff - rpix_ff : rpix_ff - lpix_ff);
   logic [DW-1:0] acc_idx_ff;

   for (genvar i = 0; i < NCand; i++) begin : g_cell
      ssd_cell #(.CostWidth(CW)) u_cell (
         .clock      (clock),
         .clear      (clear_ff),
         .add_en     (add_ff && acc_idx_ff == DW'(i)),
         .add_value  (absd),
         .shift_value((i == NCand-1) ? '0 : cost[(i+1) % NCand]),
         .shift_en   (shift_ff),
         .cost       (cost[i])
      );
   end

   // search and subpixel arithmetic
   logic [CW-1:0] best_ff, prev_ff, k1_ff, k3_ff;
   logic [12:0] best_d_ff, sd_ff;
   logic        sign_ff;
   logic [NW-1:0] num_ff, dsh_ff;
   logic [3:0]  quo_ff;
   logic [1:0]  dcnt_ff;
   logic [9:0]  q4_ff;
   logic [13:0] cost_out_ff;
   logic        interp_ff, rsp_valid_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {cost_out_ff, q4_ff};
   assign rsp_tuser  = interp_ff;

   // query inside the image accepted in this cycle
   wire q_go = req_tvalid && req_tready && cmd == ssd_pkg::CmdQuery
               && {4'd0, q_row} < h_sat && {4'd0, q_col} < w_sat;
   // output register free for a new result
   wire out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= 2'd0;
         clear_ff     <= 1'b0;
         add_ff       <= 1'b0;
         shift_ff     <= 1'b0;
      end else begin
         clear_ff     <= q_go;
         add_ff       <= (state_ff == S_READ);
         shift_ff     <= (state_ff == S_ACC) || (state_ff == S_SEARCH);
         rsp_valid_ff <= (state_ff == S_DONE && out_free) || (rsp_valid_ff && !rsp_tready);
         unique case (state_ff)
            S_IDLE: begin
               if (q_go) begin
                  r0_ff <= r0_in; r1_ff <= r1_in; c0_ff <= c0_in; c1_ff <= c1_in;
                  maxd_ff <= maxd_in;
                  r_ff <= r0_in; c_ff <= c0_in; d_ff <= '0;
                  state_ff <= S_ADDR;
               end
            end
            S_ADDR: state_ff <= S_READ;   // address presented, data registering
            S_READ: begin
               acc_idx_ff <= d_ff[DW-1:0];
               // step the window scan
               if (c_ff != c1_ff) c_ff <= c_ff + 13'd1;
               else begin
                  c_ff <= c0_ff;
                  if (r_ff != r1_ff) r_ff <= r_ff + 13'd1;
                  else begin
                     r_ff <= r0_ff;
                     d_ff <= d_ff + 13'd1;
                  end
               end
               if (c_ff == c1_ff && r_ff == r1_ff && d_ff == maxd_ff) state_ff <= S_ACC;
               else state_ff <= S_ADDR;
            end
            S_ACC: begin
               // last pixel lands in its cell at this edge
               sd_ff <= '0;
               state_ff <= S_SEARCH;
            end
            S_SEARCH: begin
               // cost[0] holds candidate sd_ff; first minimum wins
               if (sd_ff == 13'd0) begin
                  best_ff <= cost[0]; best_d_ff <= '0;
               end else if (cost[0] < best_ff) begin
                  best_ff <= cost[0]; best_d_ff <= sd_ff; k1_ff <= prev_ff;
               end
               if (sd_ff != 13'd0 && sd_ff == best_d_ff + 13'd1) k3_ff <= cost[0];
               prev_ff <= cost[0];
               if (sd_ff == maxd_ff) state_ff <= S_PREP;
               else sd_ff <= sd_ff + 13'd1;
            end
            S_PREP: begin
               // |8*(k3-k1)| over k1 - 2*k2 + k3, quotient at most 8
               sign_ff <= k3_ff < k1_ff;
               num_ff  <= NW'({((k3_ff < k1_ff) ? k1_ff - k3_ff : k3_ff - k1_ff), 3'b000});
               dsh_ff  <= (NW'(k1_ff) + NW'(k3_ff) - NW'({best_ff, 1'b0})) << 3;
               quo_ff  <= '0;
               dcnt_ff <= 2'd3;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (num_ff >= dsh_ff) begin
                  num_ff <= num_ff - dsh_ff; quo_ff <= {quo_ff[2:0], 1'b1};
               end else begin
                  quo_ff <= {quo_ff[2:0], 1'b0};
               end
               dsh_ff <= dsh_ff >> 1;
               if (dcnt_ff == 2'd0) state_ff <= S_DONE;
               else dcnt_ff <= dcnt_ff - 2'd1;
            end
            S_DONE: begin
               if (out_free) begin
                  cost_out_ff <= best_ff[13:0];
                  if (best_d_ff != 13'd0 && best_d_ff != maxd_ff) begin
                     interp_ff <= 1'b1;
                     q4_ff <= sign_ff ? 10'({best_d_ff, 4'd0} + 17'(quo_ff))
                                      : 10'({best_d_ff, 4'd0} - 17'(quo_ff));
                  end else begin
                     interp_ff <= 1'b0;
                     q4_ff <= 10'({best_d_ff, 4'd0});
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
